[design/insort_pkg.sv]
// Package for the insertion sorter: word types on the input and output channels,
// plus the command struct that the top level broadcasts to the sort cells.
// No dependencies.
package insort_pkg;

  localparam int unsigned FIELD_WIDTH = 16;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] value;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] sorted_value;
    logic                          end_of_run;
    logic                          overflow;
  } out_word_t;

  // Broadcast to every cell: insert the search value, or shift toward cell 0.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_cmd_t;

endpackage

[design/insertion_sorter.sv]
// Insertion sorter top level: chain of compare-and-shift cells, fill count,
// drain control and output register. Depends on insort_pkg and insort_cell.
//
// channel | ports                          | word
// --------+--------------------------------+----------------------------------
// input   | in_valid, in_ready, in_data    | value, last
// output  | out_valid, out_ready, out_data | sorted_value, end_of_run, overflow
//
// Each word is inserted as it is accepted; words can arrive back to back.
// A word flagged last starts a drain of the N stored words at one word
// per cycle while out_ready is high; in_ready is low for the whole drain.
// Reset (rst_n, synchronous) clears the count, drain, overflow and output valid state.
// Output stalls hold the chain in place; nothing is lost or repeated.
module insertion_sorter #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  insort_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output insort_pkg::out_word_t out_data
);
  import insort_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          drain_r, drain_nxt;
  logic                          dropped_r, dropped_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_r, out_nxt;

  logic                          in_fire;
  logic                          full;
  logic                          out_load;
  cell_cmd_t                     cmd;
  logic signed [VALUE_WIDTH-1:0] ins_val;
  logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic                          cell_gt  [DEPTH];
  logic signed [FIELD_WIDTH-1:0] head_word;

  // --- width adaptation between the 16-bit field and the store width ---
  generate
    if (VALUE_WIDTH > FIELD_WIDTH) begin : g_wide
      assign ins_val   = {{(VALUE_WIDTH-FIELD_WIDTH){in_data.value[FIELD_WIDTH-1]}},
                          in_data.value};
      assign head_word = cell_val[0][FIELD_WIDTH-1:0];
    end else if (VALUE_WIDTH == FIELD_WIDTH) begin : g_same
      assign ins_val   = in_data.value;
      assign head_word = cell_val[0];
    end else begin : g_narrow
      // value taken as VALUE_WIDTH bits; read back sign-extended to 16
      assign ins_val   = in_data.value[VALUE_WIDTH-1:0];
      assign head_word = {{(FIELD_WIDTH-VALUE_WIDTH){cell_val[0][VALUE_WIDTH-1]}},
                          cell_val[0]};
    end
  endgenerate

  // --- handshake ---
  assign in_ready  = !drain_r;
  assign in_fire   = in_valid && in_ready;
  assign full      = count_r == CNT_W'(DEPTH);
  // during a drain, pull the head word whenever the output register is free or being emptied
  assign out_load  = drain_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cmd.insert = in_fire && !full;
  assign cmd.shift  = out_load;

  // --- cell chain: left neighbor feeds inserts, right neighbor feeds drain ---
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] lv;
      logic                          lg;
      logic signed [VALUE_WIDTH-1:0] rv;
      if (i == 0) begin : g_first
        assign lv = '0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lv = cell_val[i-1];
        assign lg = cell_gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign rv = cell_val[i];
      end else begin : g_inner
        assign rv = cell_val[i+1];
      end
      insort_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W),
        .INDEX       (i)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .ins_val   (ins_val),
        .count     (count_r),
        .left_val  (lv),
        .left_gt   (lg),
        .right_val (rv),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end
  endgenerate

  // --- count, drain and output control ---
  always_comb begin
    count_nxt     = count_r;
    drain_nxt     = drain_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (in_data.last) begin
        drain_nxt = 1'b1;
      end
    end

    if (out_load) begin
      out_valid_nxt        = 1'b1;
      out_nxt.sorted_value = head_word;
      out_nxt.end_of_run   = count_r == CNT_W'(1);
      out_nxt.overflow     = dropped_r;
      count_nxt            = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drain_r     <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      drain_r     <= drain_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

[design/insort_cell.sv]
// One compare-and-shift cell of the insertion sorter chain.
// Depends on insort_pkg (cell_cmd_t).
module insort_cell #(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk,
  input  insort_pkg::cell_cmd_t         cmd,
  input  logic signed [VALUE_WIDTH-1:0] ins_val,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic                          left_gt,
  input  logic signed [VALUE_WIDTH-1:0] right_val,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic                          gt
);
  import insort_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;
  logic                          occ;
  logic                          tail;

  assign occ  = CNT_W'(INDEX) < count;
  assign tail = CNT_W'(INDEX) == count;
  // strict compare keeps equal values in arrival order
  assign gt   = occ && (val_r > ins_val);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.insert && (gt || tail)) begin
      val_nxt = left_gt ? left_val : ins_val;
    end else if (cmd.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
